// ===== src/lrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrc_pkg: register cache shared definitions
// Sizes, command codes, cell entry and result types, free list reset helper.
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam int NUM_REGS    = 32;
  localparam int VAR_ID_BITS = 16;
  localparam int REG_W       = $clog2(NUM_REGS);
  localparam int KEY_W       = VAR_ID_BITS + 1;

  // fixed port widths
  localparam int PORT_ID_W   = 16;
  localparam int PORT_REG_W  = 5;
  localparam int MASK_W      = 32;

  localparam logic [MASK_W-1:0] MASK_RESET = 32'h5FFF_FFE8;

  // results per request and the buffer count width
  localparam int RES_MAX = 3;
  localparam int CNT_W   = $clog2(RES_MAX + 1);

  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_GRANT = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // one recency slot: global flag sits above the id bits in key
  typedef struct packed {
    logic             occ;
    logic [REG_W-1:0] reg_idx;
    logic [KEY_W-1:0] key;
    logic             dirty;
  } entry_t;

  typedef struct packed {
    logic             clear;
    logic             cmp_en;
    logic             upd_en;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

  typedef struct packed {
    cmd_t                  cmd_kind;
    logic [PORT_REG_W-1:0] reg_num;
    logic [PORT_ID_W-1:0]  mem_var_id;
    logic                  mem_global;
    logic                  last;
  } result_t;

  // registers above the mask width are never allocatable
  function automatic logic [NUM_REGS-1:0] free_init(input logic [MASK_W-1:0] mask);
    logic [NUM_REGS-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      if (i < MASK_W) r[i] = mask[i[4:0]];
    end
    return r;
  endfunction

endpackage

// ===== src/lrc_if.sv =====
// ----------------------------------------------------------------------------
// lrc_if: register cache channels
// Request, result and mask write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lrc_req_if import lrc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [PORT_ID_W-1:0] var_id;
  logic                 var_global;

  modport source (output valid, req_type, var_id, var_global, input ready);
  modport sink   (input valid, req_type, var_id, var_global, output ready);
endinterface

interface lrc_res_if import lrc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cmd_t                  cmd_kind;
  logic [PORT_REG_W-1:0] reg_num;
  logic [PORT_ID_W-1:0]  mem_var_id;
  logic                  mem_global;
  logic                  last;

  modport source (output valid, cmd_kind, reg_num, mem_var_id, mem_global, last,
                  input ready);
  modport sink   (input valid, cmd_kind, reg_num, mem_var_id, mem_global, last,
                  output ready);
endinterface

interface lrc_cfg_if import lrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] alloc_mask;

  modport source (output valid, alloc_mask, input ready);
  modport sink   (input valid, alloc_mask, output ready);
endinterface

// ===== src/lrc_cell.sv =====
// ----------------------------------------------------------------------------
// lrc_cell: one recency slot
// Holds one cached register, compares its key, and takes its left neighbor's
// entry when the move-to-front shift reaches it.
// ----------------------------------------------------------------------------
module lrc_cell import lrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       sel,
  input  logic       shift_in,
  output logic       shift_out,
  input  entry_t     left,
  output entry_t     ent,
  output logic       hit
);

  // a slot shifts when the move point is here or further right
  assign shift_out = sel | shift_in;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      ent.occ <= 1'b0;
      hit     <= 1'b0;
    end else begin
      if (ctrl.cmp_en) hit <= ent.occ && (ent.key == ctrl.key);
      if (ctrl.upd_en && shift_out) ent <= left;
    end
  end

endmodule

// ===== src/lrc_free_list.sv =====
// ----------------------------------------------------------------------------
// lrc_free_list: free register pool
// Unused allocatable registers, handed out highest first.
// ----------------------------------------------------------------------------
module lrc_free_list import lrc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [MASK_W-1:0] mask,
  input  logic              pop,
  output logic              empty,
  output logic [REG_W-1:0]  top
);

  logic [NUM_REGS-1:0] free_mask;

  always_comb begin
    top = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      if (free_mask[i]) top = REG_W'(i);
    end
  end

  assign empty = ~|free_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_mask <= free_init(MASK_RESET);
    end else if (load) begin
      free_mask <= free_init(mask);
    end else if (pop) begin
      free_mask[top] <= 1'b0;
    end
  end

endmodule

// ===== src/lrc_res_buf.sv =====
// ----------------------------------------------------------------------------
// lrc_res_buf: result buffer
// Holds the up to three results of one request and sends them in order.
// ----------------------------------------------------------------------------
module lrc_res_buf import lrc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic [CNT_W-1:0]          load_cnt,
  input  result_t [RES_MAX-1:0]     load_res,
  output logic                      empty,
  lrc_res_if.source                 res
);

  result_t [RES_MAX-1:0] slot;
  logic    [CNT_W-1:0]   cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      slot <= load_res;
      cnt  <= load_cnt;
    end else if (res.valid && res.ready) begin
      for (int i = 0; i < RES_MAX - 1; i++) slot[i] <= slot[i+1];
      cnt <= cnt - 1'b1;
    end
  end

  assign empty          = (cnt == '0);
  assign res.valid      = !empty;
  assign res.cmd_kind   = slot[0].cmd_kind;
  assign res.reg_num    = slot[0].reg_num;
  assign res.mem_var_id = slot[0].mem_var_id;
  assign res.mem_global = slot[0].mem_global;
  assign res.last       = slot[0].last;

endmodule

// ===== src/lru_register_cache_core.sv =====
// ----------------------------------------------------------------------------
// lru_register_cache_core: fully associative lru register cache
// A row of recency cells (front is most recently used) does the key search
// and the move-to-front shift; a free pool hands out unused registers.
// ----------------------------------------------------------------------------
// flow: a request passes the compare state and the shift state, which loads
//   n = 1..3 results; the buffer sends one result per cycle while res.ready
//   is high, and no new request is taken before the buffer is empty
// reset: cache empty, free pool loaded from alloc mask 0x5FFFFFE8 at once;
//   a mask write empties the cache and reloads the pool together
module lru_register_cache_core import lrc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lrc_req_if.sink   req,
  lrc_res_if.source res,
  lrc_cfg_if.sink   cfg
);

  typedef enum logic [1:0] {S_IDLE, S_LOOKUP, S_UPDATE} state_t;

  state_t           state;
  logic             req_wr;
  logic [KEY_W-1:0] req_key;

  logic req_fire, cfg_fire, buf_empty;
  logic free_empty, pop;
  logic [REG_W-1:0] free_top;

  cell_ctrl_t          cell_ctrl;
  entry_t              ent  [NUM_REGS];
  entry_t              left [NUM_REGS];
  entry_t              new_ent, pick;
  logic [NUM_REGS-1:0] hit_vec, occ_vec, tail_vec, sel_vec, pick_vec;
  logic [NUM_REGS:0]   shift_chain;
  logic                any_hit;

  logic [CNT_W-1:0]      res_cnt;
  result_t [RES_MAX-1:0] res_list;

  function automatic result_t mk(input cmd_t kind, input logic [REG_W-1:0] r,
                                 input logic [KEY_W-1:0] k, input logic l);
    result_t o;
    o.cmd_kind   = kind;
    o.reg_num    = PORT_REG_W'(r);
    o.mem_var_id = PORT_ID_W'(k[VAR_ID_BITS-1:0]);
    o.mem_global = k[KEY_W-1];
    o.last       = l;
    return o;
  endfunction

  // mask writes only between requests
  assign cfg.ready = (state == S_IDLE) && buf_empty;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign req.ready = (state == S_IDLE) && buf_empty;
  assign req_fire  = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (req_fire) state <= S_LOOKUP;
        S_LOOKUP: state <= S_UPDATE;
        S_UPDATE: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
    if (req_fire) begin
      req_wr  <= req.req_type;
      req_key <= {req.var_global, VAR_ID_BITS'(req.var_id)};
    end
  end

  assign cell_ctrl.clear  = cfg_fire;
  assign cell_ctrl.cmp_en = (state == S_LOOKUP);
  assign cell_ctrl.upd_en = (state == S_UPDATE);
  assign cell_ctrl.key    = req_key;

  assign shift_chain[NUM_REGS] = 1'b0;

  for (genvar j = 0; j < NUM_REGS; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign left[j] = new_ent;
    end else begin : g_body
      assign left[j] = ent[j-1];
    end
    assign occ_vec[j] = ent[j].occ;

    lrc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl),
      .sel       (sel_vec[j]),
      .shift_in  (shift_chain[j+1]),
      .shift_out (shift_chain[j]),
      .left      (left[j]),
      .ent       (ent[j]),
      .hit       (hit_vec[j])
    );
  end

  // occupied slots are packed at the front, the last one is the lru victim
  assign tail_vec = occ_vec & ~(occ_vec >> 1);
  assign any_hit  = |hit_vec;
  assign pick_vec = any_hit ? hit_vec : tail_vec;

  always_comb begin
    pick = '0;
    for (int j = 0; j < NUM_REGS; j++) begin
      if (pick_vec[j]) pick = entry_t'(pick | ent[j]);
    end
  end

  always_comb begin
    new_ent.occ     = 1'b1;
    new_ent.reg_idx = pick.reg_idx;
    new_ent.key     = req_key;
    new_ent.dirty   = req_wr;
    sel_vec  = '0;
    res_list = '0;
    res_cnt  = CNT_W'(1);
    priority if (any_hit) begin
      sel_vec       = hit_vec;
      new_ent.dirty = pick.dirty | req_wr;
      res_list[0]   = mk(CMD_GRANT, pick.reg_idx, req_key, 1'b1);
    end else if (!free_empty) begin
      // new entry enters at the front, every slot moves back
      sel_vec[NUM_REGS-1] = 1'b1;
      new_ent.reg_idx     = free_top;
      res_list[0]         = mk(CMD_LOAD, free_top, req_key, 1'b0);
      res_list[1]         = mk(CMD_GRANT, free_top, req_key, 1'b1);
      res_cnt             = CNT_W'(2);
    end else if (occ_vec[0]) begin
      sel_vec = tail_vec;
      if (pick.dirty) begin
        res_list[0] = mk(CMD_STORE, pick.reg_idx, pick.key, 1'b0);
        res_list[1] = mk(CMD_LOAD, pick.reg_idx, req_key, 1'b0);
        res_list[2] = mk(CMD_GRANT, pick.reg_idx, req_key, 1'b1);
        res_cnt     = CNT_W'(3);
      end else begin
        res_list[0] = mk(CMD_LOAD, pick.reg_idx, req_key, 1'b0);
        res_list[1] = mk(CMD_GRANT, pick.reg_idx, req_key, 1'b1);
        res_cnt     = CNT_W'(2);
      end
    end else begin
      res_list[0] = mk(CMD_NONE, '0, '0, 1'b1);
    end
  end

  assign pop = (state == S_UPDATE) && !any_hit && !free_empty;

  lrc_free_list u_free (
    .clk   (clk),
    .rst   (rst),
    .load  (cfg_fire),
    .mask  (cfg.alloc_mask),
    .pop   (pop),
    .empty (free_empty),
    .top   (free_top)
  );

  lrc_res_buf u_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (state == S_UPDATE),
    .load_cnt (res_cnt),
    .load_res (res_list),
    .empty    (buf_empty),
    .res      (res)
  );

  a_update_emits: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDATE |=> res.valid)
    else $error("no result after cache update");

  a_occ_packed: assert property (@(posedge clk) disable iff (rst)
    ((occ_vec >> 1) & ~occ_vec) == '0)
    else $error("recency slots not packed at the front");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDATE |-> $onehot0(hit_vec))
    else $error("key held in more than one slot");

endmodule
